[hdl/bse_pkg.sv]
// Shared constants, types and codes of the Burgers stencil engine.
package bse_pkg;

  localparam int GRID_X    = 32;
  localparam int GRID_Y    = 32;
  localparam int FRAC_BITS = 12;

  localparam int CELLS    = GRID_X * GRID_Y;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int ADDR_W   = CELL_W + 1;
  localparam int STEP_LEN = CELLS + GRID_X;
  localparam int CNT_W    = $clog2(STEP_LEN + 1);
  localparam int TAPS     = 2 * GRID_X + 1;
  localparam int GX_W     = $clog2(GRID_X);
  localparam int GY_W     = $clog2(GRID_Y);

  // speed width: ax plus the rounded b*q product
  localparam int SP_W  = (((32 - FRAC_BITS) > 16) ? (32 - FRAC_BITS) : 16) + 1;
  localparam int T_W   = 33 + SP_W;
  localparam int ACC_W = T_W + 3;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] REG_AX  = 3'd0;
  localparam logic [2:0] REG_AY  = 3'd1;
  localparam logic [2:0] REG_B   = 3'd2;
  localparam logic [2:0] REG_DTX = 3'd3;
  localparam logic [2:0] REG_DTY = 3'd4;
  localparam logic [2:0] REG_CX  = 3'd5;
  localparam logic [2:0] REG_CY  = 3'd6;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] b;
    logic [14:0]        dtdx;
    logic [14:0]        dtdy;
    logic [14:0]        cx;
    logic [14:0]        cy;
  } cfg_t;

  typedef struct packed {
    logic feed;
    logic start;
  } feed_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [15:0]       u;
    logic [15:0]       v;
  } wr_t;

endpackage

[hdl/burgers_2d_stencil_engine.sv]
// Top level: item control, register port, grid memory and result register.
//
// Input channel (in_valid/in_stall) carries items of three kinds: write one
// cell of u and v, run one time step, or read one cell. Only a read gives a
// result, on the output channel (out_valid/out_stall) through an output
// register. A write goes to the grid RAM when it is accepted. A read passes
// through the registered RAM read port into the output register and waits
// there while the receiver stalls; further write and step items are still
// taken meanwhile, a second read waits for the slot. A step streams the
// current page from the grid RAM one cell per cycle, as the single RAM read
// port allows, through a window of 2*GRID_X+1 cells; it reads GRID_X cells
// more than the grid holds, then drains the arithmetic pipeline. The new
// values go to the other page, then the page flips.
// After reset the block zeroes page 0 and holds in_stall high meanwhile;
// the APB register port works throughout and its registers return to their
// reset values. The user must write registers only while no item is in
// progress; the block itself does not enforce this.
module burgers_2d_stencil_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  x_index,
  input  logic [4:0]  y_index,
  input  logic signed [15:0] u_in,
  input  logic signed [15:0] v_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] u_out,
  output logic signed [15:0] v_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bse_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_STEP  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;
  feed_t  ctl;
  wr_t    swr;
  logic   busy;
  logic   page;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_inside;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata;

  logic              accept, in_grid, out_free;
  logic [CELL_W-1:0] item_addr;
  logic [2:0]        reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_grid  = (32'(x_index) < GRID_X) && (32'(y_index) < GRID_Y);
  assign item_addr = CELL_W'(32'(y_index) * GRID_X + 32'(x_index));
  assign out_free = !out_valid || !out_stall;

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ax   <= 16'sd4096;
      cfg.ay   <= 16'sd4096;
      cfg.b    <= 16'sd410;
      cfg.dtdx <= 15'd259;
      cfg.dtdy <= 15'd259;
      cfg.cx   <= 15'd10;
      cfg.cy   <= 15'd10;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_AX:  cfg.ax   <= pwdata[15:0];
        REG_AY:  cfg.ay   <= pwdata[15:0];
        REG_B:   cfg.b    <= pwdata[15:0];
        REG_DTX: cfg.dtdx <= pwdata[14:0];
        REG_DTY: cfg.dtdy <= pwdata[14:0];
        REG_CX:  cfg.cx   <= pwdata[14:0];
        REG_CY:  cfg.cy   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AX:  prdata = {16'h0000, cfg.ax};
      REG_AY:  prdata = {16'h0000, cfg.ay};
      REG_B:   prdata = {16'h0000, cfg.b};
      REG_DTX: prdata = {17'h00000, cfg.dtdx};
      REG_DTY: prdata = {17'h00000, cfg.dtdy};
      REG_CX:  prdata = {17'h00000, cfg.cx};
      REG_CY:  prdata = {17'h00000, cfg.cy};
      default: prdata = 32'h0000_0000;
    endcase
  end

  // memory ports and sequencing
  always_comb begin
    state_next = state;
    we        = 1'b0;
    waddr     = {1'b0, cnt[CELL_W-1:0]};
    wdata     = 32'h0000_0000;
    raddr     = {page, item_addr};
    ctl.feed  = 1'b0;
    ctl.start = 1'b0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (32'(cnt) == CELLS - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_WRITE: begin
              we    = in_grid;
              waddr = {page, item_addr};
              wdata = {u_in, v_in};
            end
            KIND_STEP: begin
              ctl.start  = 1'b1;
              state_next = ST_STEP;
            end
            KIND_READ: state_next = ST_READ;
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        raddr    = {page, cnt[CELL_W-1:0]};
        ctl.feed = 1'b1;
        if (32'(cnt) == STEP_LEN - 1) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_next = ST_IDLE;
      end
      ST_READ: begin
        raddr = rd_addr;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (swr.we) begin
      we    = 1'b1;
      waddr = {~page, swr.addr};
      wdata = {swr.u, swr.v};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr   <= {page, item_addr};
      rd_inside <= in_grid;
    end
    if (state == ST_READ && out_free) begin
      u_out <= rd_inside ? rdata[31:16] : 16'sd0;
      v_out <= rd_inside ? rdata[15:0]  : 16'sd0;
    end
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      page      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_STEP) begin
        cnt <= (state_next == state) ? cnt + 1'b1 : '0;
      end else begin
        cnt <= '0;
      end
      if (state == ST_DRAIN && !busy) page <= ~page;
      if (state == ST_READ && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  bse_ram #(
    .DEPTH (2 * CELLS),
    .WIDTH (32)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bse_stencil u_stencil (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctl   (ctl),
    .rdata (rdata),
    .wr    (swr),
    .busy  (busy)
  );

endmodule

[hdl/bse_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module bse_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bse_stencil.sv]
// Raster window over the old page and the pipelined cell update.
module bse_stencil (
  input  logic                  clk,
  input  logic                  rst,
  input  bse_pkg::cfg_t         cfg,
  input  bse_pkg::feed_t        ctl,
  input  logic [31:0]           rdata,
  output bse_pkg::wr_t          wr,
  output logic                  busy
);
  import bse_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
  localparam logic signed [31:0]      BP_HALF = 32'sd1 <<< (FRAC_BITS - 1);

  logic [31:0] sh [TAPS];
  logic        feed_d;
  logic [CNT_W-1:0] k;
  logic [GX_W-1:0]  cxp;
  logic [GY_W-1:0]  cyp;

  logic              tap_v, tap_edge;
  logic [CELL_W-1:0] tap_a;

  // stage 1
  logic              v1, e1;
  logic [CELL_W-1:0] a1;
  logic signed [15:0] qc1 [2];
  logic signed [16:0] dx1 [2];
  logic signed [16:0] dy1 [2];
  logic signed [18:0] lx1 [2];
  logic signed [18:0] ly1 [2];
  logic signed [31:0] bp1 [2];
  // stage 2
  logic              v2, e2;
  logic [CELL_W-1:0] a2;
  logic signed [15:0]     qc2 [2];
  logic signed [SP_W-1:0] sp2 [2];
  logic signed [32:0]     mx2 [2];
  logic signed [32:0]     my2 [2];
  logic signed [34:0]     fx2 [2];
  logic signed [34:0]     fy2 [2];
  // stage 3
  logic              v3, e3;
  logic [CELL_W-1:0] a3;
  logic signed [15:0]    qc3 [2];
  logic signed [T_W-1:0] tx3 [2];
  logic signed [T_W-1:0] ty3 [2];
  logic signed [34:0]    fx3 [2];
  logic signed [34:0]    fy3 [2];
  // stage 4
  logic              v4, e4;
  logic [CELL_W-1:0] a4;
  logic signed [ACC_W-1:0] acc4 [2];

  logic signed [15:0] qn [2], qe [2], qc [2], qw [2], qs [2];
  logic signed [ACC_W-1:0] rs [2];
  logic [15:0] res [2];

  always_comb begin
    qn[0] = sh[0][31:16];          qn[1] = sh[0][15:0];
    qe[0] = sh[GRID_X-1][31:16];   qe[1] = sh[GRID_X-1][15:0];
    qc[0] = sh[GRID_X][31:16];     qc[1] = sh[GRID_X][15:0];
    qw[0] = sh[GRID_X+1][31:16];   qw[1] = sh[GRID_X+1][15:0];
    qs[0] = sh[2*GRID_X][31:16];   qs[1] = sh[2*GRID_X][15:0];
    for (int l = 0; l < 2; l++) begin
      rs[l] = (acc4[l] + HALF) >>> (2 * FRAC_BITS);
      if (e4) begin
        res[l] = 16'h0000;
      end else if (rs[l] > SAT_HI) begin
        res[l] = 16'h7FFF;
      end else if (rs[l] < SAT_LO) begin
        res[l] = 16'h8000;
      end else begin
        res[l] = rs[l][15:0];
      end
    end
  end

  // window shift line and center cursor
  always_ff @(posedge clk) begin
    if (feed_d) begin
      sh[0] <= rdata;
      for (int i = 1; i < TAPS; i++) begin
        sh[i] <= sh[i-1];
      end
    end
    if (rst) begin
      feed_d <= 1'b0;
      tap_v  <= 1'b0;
      k      <= '0;
      cxp    <= '0;
      cyp    <= '0;
    end else begin
      feed_d <= ctl.feed;
      tap_v  <= 1'b0;
      if (ctl.start) begin
        k   <= '0;
        cxp <= '0;
        cyp <= '0;
      end else if (feed_d) begin
        k <= k + 1'b1;
        if (32'(k) >= GRID_X) begin
          tap_v    <= 1'b1;
          tap_a    <= CELL_W'(32'(k) - GRID_X);
          tap_edge <= (cxp == '0) || (32'(cxp) == GRID_X - 1) ||
                      (cyp == '0) || (32'(cyp) == GRID_Y - 1);
          if (32'(cxp) == GRID_X - 1) begin
            cxp <= '0;
            cyp <= cyp + 1'b1;
          end else begin
            cxp <= cxp + 1'b1;
          end
        end
      end
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      qc1[l] <= qc[l];
      dx1[l] <= 17'(qc[l]) - 17'(qw[l]);
      dy1[l] <= 17'(qc[l]) - 17'(qs[l]);
      lx1[l] <= 19'(qe[l]) + 19'(qw[l]) - (19'(qc[l]) <<< 1);
      ly1[l] <= 19'(qs[l]) + 19'(qn[l]) - (19'(qc[l]) <<< 1);
      bp1[l] <= cfg.b * qc[l];

      qc2[l] <= qc1[l];
      mx2[l] <= $signed({1'b0, cfg.dtdx}) * dx1[l];
      my2[l] <= $signed({1'b0, cfg.dtdy}) * dy1[l];
      fx2[l] <= $signed({1'b0, cfg.cx}) * lx1[l];
      fy2[l] <= $signed({1'b0, cfg.cy}) * ly1[l];

      qc3[l] <= qc2[l];
      fx3[l] <= fx2[l];
      fy3[l] <= fy2[l];

      acc4[l] <= (ACC_W'(qc3[l]) <<< (2 * FRAC_BITS)) - ACC_W'(tx3[l]) - ACC_W'(ty3[l])
                 + (ACC_W'(fx3[l]) <<< FRAC_BITS) + (ACC_W'(fy3[l]) <<< FRAC_BITS);
    end
    // b*q rounded to nearest, ties up
    sp2[0] <= SP_W'(cfg.ax) + SP_W'((bp1[0] + BP_HALF) >>> FRAC_BITS);
    sp2[1] <= SP_W'(cfg.ay) + SP_W'((bp1[1] + BP_HALF) >>> FRAC_BITS);
    // lane 0 is u, lane 1 is v; both use sx for x and sy for y
    for (int l = 0; l < 2; l++) begin
      tx3[l] <= T_W'(mx2[l]) * T_W'(sp2[0]);
      ty3[l] <= T_W'(my2[l]) * T_W'(sp2[1]);
    end

    a1 <= tap_a; e1 <= tap_edge;
    a2 <= a1;    e2 <= e1;
    a3 <= a2;    e3 <= e2;
    a4 <= a3;    e4 <= e3;
    wr.addr <= a4;
    wr.u    <= res[0];
    wr.v    <= res[1];

    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      wr.we <= 1'b0;
    end else begin
      v1 <= tap_v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      wr.we <= v4;
    end
  end

  assign busy = feed_d | tap_v | v1 | v2 | v3 | v4 | wr.we;

endmodule
